FILE: rtl/dhcprop_pkg.sv
// ----------------------------------------------------------------------------
// dhcprop_pkg: shared types and constants of the DHCP reply option parser
// Holds the byte classification that passes from the front end to the parser
// back end, the queue geometry, the result record and the protocol codes.
// ----------------------------------------------------------------------------
package dhcprop_pkg;

    // Queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Message layout.
    localparam int MIN_MSG_BYTES  = 244;
    localparam int YIADDR_FIRST   = 16;
    localparam int YIADDR_LAST    = 19;
    localparam int COOKIE_FIRST   = 236;
    localparam int COOKIE_LAST    = 239;
    localparam int OPTIONS_FIRST  = 240;

    // Option codes.
    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_MASK   = 8'd1;
    localparam logic [7:0] OPT_ROUTER = 8'd3;
    localparam logic [7:0] OPT_DNS    = 8'd6;
    localparam logic [7:0] OPT_LEASE  = 8'd51;
    localparam logic [7:0] OPT_TYPE   = 8'd53;
    localparam logic [7:0] OPT_END    = 8'd255;

    // Message types accepted as a reply.
    localparam logic [7:0] TYPE_OFFER = 8'd2;
    localparam logic [7:0] TYPE_ACK   = 8'd5;

    // Result status codes.
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_SHORT     = 3'd1;
    localparam logic [2:0] STATUS_BAD_COOKIE = 3'd2;
    localparam logic [2:0] STATUS_BAD_TYPE  = 3'd3;
    localparam logic [2:0] STATUS_TOO_LONG  = 3'd4;

    // Slots of the four word-valued options.
    localparam logic [1:0] SLOT_MASK   = 2'd0;
    localparam logic [1:0] SLOT_ROUTER = 2'd1;
    localparam logic [1:0] SLOT_DNS    = 2'd2;
    localparam logic [1:0] SLOT_LEASE  = 2'd3;

    // Classification of one byte, worked out by the front end.
    typedef struct packed {
        logic last;        // final byte of the message
        logic too_long;    // message ran past the size limit (valid with last)
        logic short_msg;   // message shorter than the minimum (valid with last)
        logic yiaddr;      // byte of the offered address field
        logic cookie_bad;  // cookie byte that does not match
        logic walk;        // byte lies in the options area
    } byte_kind_t;

    typedef struct packed {
        byte_kind_t kind;
        logic [7:0] data;
    } queue_entry_t;

    // One result record.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] offered_ip;
        logic [7:0]  msg_type;
        logic [31:0] subnet_mask;
        logic [31:0] router;
        logic [31:0] dns_server;
        logic [31:0] lease_time;
        logic [3:0]  found;    // mask, router, DNS, lease from the lowest bit up
    } result_t;

    // Expected magic cookie byte for cookie offset 0 to 3.
    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h63;
            2'd1:    val = 8'h82;
            2'd2:    val = 8'h53;
            default: val = 8'h63;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/dhcprop_front.sv
// ----------------------------------------------------------------------------
// dhcprop_front: byte counter and classifier
// Counts the bytes of each message, marks the offered address and cookie
// bytes, the options area and bytes beyond the size limit, and pushes each
// classified word into the queue.
// ----------------------------------------------------------------------------
module dhcprop_front #(
    parameter int MAX_MSG_BYTES = 2048
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic [7:0]               in_data,
    input  logic                     in_last,
    input  logic                     queue_ready,
    output logic                     push,
    output dhcprop_pkg::queue_entry_t push_entry
);

    localparam int PW = $clog2(MAX_MSG_BYTES + 1);
    localparam logic [PW-1:0] POS_LIMIT      = PW'(MAX_MSG_BYTES);
    localparam logic [PW-1:0] POS_SHORT_LAST = PW'(dhcprop_pkg::MIN_MSG_BYTES - 1);
    localparam logic [PW-1:0] POS_YI_FIRST   = PW'(dhcprop_pkg::YIADDR_FIRST);
    localparam logic [PW-1:0] POS_YI_LAST    = PW'(dhcprop_pkg::YIADDR_LAST);
    localparam logic [PW-1:0] POS_CK_FIRST   = PW'(dhcprop_pkg::COOKIE_FIRST);
    localparam logic [PW-1:0] POS_CK_LAST    = PW'(dhcprop_pkg::COOKIE_LAST);
    localparam logic [PW-1:0] POS_OPT_FIRST  = PW'(dhcprop_pkg::OPTIONS_FIRST);

    logic [PW-1:0] pos_reg, pos_next;
    logic          too_long_reg, too_long_next;
    logic          ignored;
    logic          is_cookie;

    // Classify the byte from its position in the message.
    always_comb begin
        ignored   = (pos_reg >= POS_LIMIT);
        is_cookie = !ignored && (pos_reg >= POS_CK_FIRST) && (pos_reg <= POS_CK_LAST);

        push                       = in_valid && queue_ready;
        push_entry.data            = in_data;
        push_entry.kind.last       = in_last;
        push_entry.kind.too_long   = too_long_reg || ignored;
        push_entry.kind.short_msg  = (pos_reg < POS_SHORT_LAST);
        push_entry.kind.yiaddr     = !ignored && (pos_reg >= POS_YI_FIRST)
                                     && (pos_reg <= POS_YI_LAST);
        push_entry.kind.cookie_bad = is_cookie
                                     && (in_data != dhcprop_pkg::cookie_byte(pos_reg[1:0]));
        push_entry.kind.walk       = !ignored && (pos_reg >= POS_OPT_FIRST);

        pos_next      = pos_reg;
        too_long_next = too_long_reg;
        if (push) begin
            if (in_last) begin
                pos_next      = '0;
                too_long_next = 1'b0;
            end else if (ignored) begin
                too_long_next = 1'b1;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Position counter and oversize flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            too_long_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            too_long_reg <= too_long_next;
        end
    end

endmodule

FILE: rtl/dhcprop_queue.sv
// ----------------------------------------------------------------------------
// dhcprop_queue: short queue of classified words
// A small register queue that lets the front end keep accepting words while
// the back end waits for its result to be taken.
// ----------------------------------------------------------------------------
module dhcprop_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  dhcprop_pkg::queue_entry_t push_entry,
    output logic                      push_ready,
    input  logic                      pop,
    output logic                      head_valid,
    output dhcprop_pkg::queue_entry_t head_entry
);

    dhcprop_pkg::queue_entry_t          mem_reg [dhcprop_pkg::QUEUE_DEPTH];
    logic [dhcprop_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dhcprop_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dhcprop_pkg::QCNT_W-1:0]     count_reg, count_next;

    // Occupancy and pointers.
    always_comb begin
        push_ready = (count_reg != dhcprop_pkg::QCNT_W'(dhcprop_pkg::QUEUE_DEPTH));
        head_valid = (count_reg != '0);
        head_entry = mem_reg[rd_ptr_reg];

        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/dhcprop_back.sv
// ----------------------------------------------------------------------------
// dhcprop_back: option walker and result register
// Takes classified words from the queue, captures the offered address,
// tracks the cookie, walks the options and, on the final word, forms the
// result into an output register.
// ----------------------------------------------------------------------------
module dhcprop_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      head_valid,
    input  dhcprop_pkg::queue_entry_t head_entry,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output dhcprop_pkg::result_t      out_result
);

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_VAL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic [7:0]  length_reg, length_next;
    logic [31:0] shift_reg, shift_next;
    logic        cookie_ok_reg, cookie_ok_next;
    logic [31:0] yiaddr_reg, yiaddr_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] values_reg [4];
    logic [31:0] values_next [4];
    logic [3:0]  found_reg, found_next;
    logic        ended_reg, ended_next;
    logic        out_valid_reg, out_valid_next;
    dhcprop_pkg::result_t out_reg, out_next;

    logic        finish;
    logic        slot_hit;
    logic [1:0]  slot;
    logic [7:0]  first_val;
    logic [7:0]  b;
    logic        show_opts;
    logic [2:0]  status;

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // Walk one word and form the result on the final one.
    always_comb begin
        phase_next     = phase_reg;
        code_next      = code_reg;
        remaining_next = remaining_reg;
        length_next    = length_reg;
        shift_next     = shift_reg;
        cookie_ok_next = cookie_ok_reg;
        yiaddr_next    = yiaddr_reg;
        type_next      = type_reg;
        values_next    = values_reg;
        found_next     = found_reg;
        ended_next     = ended_reg;
        out_next       = out_reg;
        finish         = 1'b0;
        slot_hit       = 1'b0;
        slot           = dhcprop_pkg::SLOT_MASK;
        first_val      = 8'd0;
        status         = dhcprop_pkg::STATUS_OK;
        show_opts      = 1'b0;
        b              = head_entry.data;

        // A final word waits until the output register can take its result.
        pop = head_valid && (!head_entry.kind.last || !out_valid_reg || out_ready);
        out_valid_next = out_valid_reg && !out_ready;

        if (pop) begin
            if (head_entry.kind.yiaddr) begin
                yiaddr_next = {yiaddr_reg[23:0], b};
            end
            if (head_entry.kind.cookie_bad) begin
                cookie_ok_next = 1'b0;
            end

            // Option walk.
            if (head_entry.kind.walk && !ended_reg) begin
                unique case (phase_reg)
                    PH_CODE: begin
                        if (b == dhcprop_pkg::OPT_END) begin
                            ended_next = 1'b1;
                        end else if (b != dhcprop_pkg::OPT_PAD) begin
                            code_next  = b;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        // A zero-length option completes here and applies nothing.
                        length_next    = b;
                        remaining_next = b;
                        shift_next     = '0;
                        phase_next     = (b == 8'd0) ? PH_CODE : PH_VAL;
                    end
                    PH_VAL: begin
                        if ((length_reg - remaining_reg) < 8'd4) begin
                            shift_next = {shift_reg[23:0], b};
                        end
                        remaining_next = remaining_reg - 1'b1;
                        if (remaining_next == 8'd0) begin
                            finish     = 1'b1;
                            phase_next = PH_CODE;
                        end
                    end
                    default: begin
                        phase_next = PH_CODE;
                    end
                endcase
            end

            // Apply a completed option.
            if (finish) begin
                case (length_reg)
                    8'd1:    first_val = shift_next[7:0];
                    8'd2:    first_val = shift_next[15:8];
                    8'd3:    first_val = shift_next[23:16];
                    default: first_val = shift_next[31:24];
                endcase
                unique case (code_reg)
                    dhcprop_pkg::OPT_MASK: begin
                        slot     = dhcprop_pkg::SLOT_MASK;
                        slot_hit = 1'b1;
                    end
                    dhcprop_pkg::OPT_ROUTER: begin
                        slot     = dhcprop_pkg::SLOT_ROUTER;
                        slot_hit = 1'b1;
                    end
                    dhcprop_pkg::OPT_DNS: begin
                        slot     = dhcprop_pkg::SLOT_DNS;
                        slot_hit = 1'b1;
                    end
                    dhcprop_pkg::OPT_LEASE: begin
                        slot     = dhcprop_pkg::SLOT_LEASE;
                        slot_hit = 1'b1;
                    end
                    default: begin
                        slot_hit = 1'b0;
                    end
                endcase
                if (code_reg == dhcprop_pkg::OPT_TYPE) begin
                    type_next = first_val;
                end else if (slot_hit && (length_reg >= 8'd4)) begin
                    values_next[slot] = shift_next;
                    found_next[slot]  = 1'b1;
                end
            end

            // Result on the final word, then back to the reset state.
            if (head_entry.kind.last) begin
                if (head_entry.kind.too_long) begin
                    status = dhcprop_pkg::STATUS_TOO_LONG;
                end else if (head_entry.kind.short_msg) begin
                    status = dhcprop_pkg::STATUS_SHORT;
                end else if (!cookie_ok_next) begin
                    status = dhcprop_pkg::STATUS_BAD_COOKIE;
                end else if ((type_next != dhcprop_pkg::TYPE_OFFER)
                             && (type_next != dhcprop_pkg::TYPE_ACK)) begin
                    status = dhcprop_pkg::STATUS_BAD_TYPE;
                end else begin
                    status = dhcprop_pkg::STATUS_OK;
                end
                show_opts = (status == dhcprop_pkg::STATUS_OK)
                            || (status == dhcprop_pkg::STATUS_BAD_TYPE);

                out_next.status      = status;
                out_next.offered_ip  = (status == dhcprop_pkg::STATUS_OK) ? yiaddr_next : '0;
                out_next.msg_type    = show_opts ? type_next : '0;
                out_next.subnet_mask = show_opts ? values_next[dhcprop_pkg::SLOT_MASK] : '0;
                out_next.router      = show_opts ? values_next[dhcprop_pkg::SLOT_ROUTER] : '0;
                out_next.dns_server  = show_opts ? values_next[dhcprop_pkg::SLOT_DNS] : '0;
                out_next.lease_time  = show_opts ? values_next[dhcprop_pkg::SLOT_LEASE] : '0;
                out_next.found       = show_opts ? found_next : '0;
                out_valid_next       = 1'b1;

                phase_next     = PH_CODE;
                code_next      = '0;
                remaining_next = '0;
                length_next    = '0;
                shift_next     = '0;
                cookie_ok_next = 1'b1;
                yiaddr_next    = '0;
                type_next      = '0;
                values_next    = '{default: '0};
                found_next     = '0;
                ended_next     = 1'b0;
            end
        end
    end

    // Parser state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_CODE;
            code_reg      <= '0;
            remaining_reg <= '0;
            length_reg    <= '0;
            shift_reg     <= '0;
            cookie_ok_reg <= 1'b1;
            yiaddr_reg    <= '0;
            type_reg      <= '0;
            values_reg    <= '{default: '0};
            found_reg     <= '0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            code_reg      <= code_next;
            remaining_reg <= remaining_next;
            length_reg    <= length_next;
            shift_reg     <= shift_next;
            cookie_ok_reg <= cookie_ok_next;
            yiaddr_reg    <= yiaddr_next;
            type_reg      <= type_next;
            values_reg    <= values_next;
            found_reg     <= found_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

endmodule

FILE: rtl/dhcp_reply_option_parser.sv
// ----------------------------------------------------------------------------
// dhcp_reply_option_parser: DHCP reply option parser
// Takes a DHCP reply a byte a word, checks its size and magic cookie, walks
// its options and gives one result word per message.
//
//   Channel | Direction | Word
//   s_axis  | in        | one message byte, tlast on the final byte
//   m_axis  | out       | status, offered address, type, four option values;
//           |           | tuser carries the four found flags
//
// One byte is taken every cycle while the queue has room. A byte passes
// the classifier into a four-word queue and is parsed from its head; the
// result word is registered as the final byte is parsed. Reset (aresetn
// low) clears the position count, the queue and all parser state. Only a
// final byte waits on m_axis_tready; the queue keeps taking bytes meanwhile
// until its four words are full, and only then does s_axis_tready drop.
// ----------------------------------------------------------------------------
module dhcp_reply_option_parser #(
    parameter int MAX_MSG_BYTES = 2048
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // rx_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status [2:0], offered_ip [34:3], msg_type [42:35], subnet_mask [74:43],
    // router [106:75], dns_server [138:107], lease_time [170:139], zeros above
    output logic [175:0] m_axis_tdata,
    // mask_found [0], router_found [1], dns_found [2], lease_found [3]
    output logic [3:0]   m_axis_tuser
);

    logic                      push;
    logic                      queue_ready;
    dhcprop_pkg::queue_entry_t push_entry;
    logic                      pop;
    logic                      head_valid;
    dhcprop_pkg::queue_entry_t head_entry;
    dhcprop_pkg::result_t      result;

    assign s_axis_tready = queue_ready;

    dhcprop_front #(
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_data     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .queue_ready (queue_ready),
        .push        (push),
        .push_entry  (push_entry)
    );

    dhcprop_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (queue_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    dhcprop_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // Pack the result word.
    assign m_axis_tdata = {5'b0, result.lease_time, result.dns_server, result.router,
                           result.subnet_mask, result.msg_type, result.offered_ip,
                           result.status};
    assign m_axis_tuser = result.found;

endmodule

FILE: tb/sv/dhcp_reply_option_parser_tb.sv
// ----------------------------------------------------------------------------
// dhcp_reply_option_parser_tb: self-checking bench of the DHCP reply parser
// Streams whole DHCP replies into the parser a byte per word and predicts the
// single result word of each reply from its own model of the address capture,
// the cookie check and the option walk. Directed replies cover the size
// limits, the cookie, the message types, pads, the end option, zero-length,
// long, repeated and truncated options. Random replies follow, mostly well
// formed with random content, mixed with noise and broken replies. The sender
// idles in bursts, and the receiver stalls on its own pattern, once for long
// enough to fill the parser's queue and stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhcp_reply_option_parser_tb;
    import dhcprop_pkg::*;

    localparam int MSG_LIMIT      = 2048;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_REPLIES = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CYCLE_LIMIT    = 3000000;

    localparam logic [7:0] COOKIE [4] = '{8'h63, 8'h82, 8'h53, 8'h63};
    localparam logic [7:0] WORD_CODES [4] = '{OPT_MASK, OPT_ROUTER, OPT_DNS, OPT_LEASE};

    typedef enum logic [1:0] {WANT_CODE, WANT_LEN, IN_VALUE} walk_state_e;

    // Predicts one result word per reply and checks the parser's output.
    class reply_scoreboard;
        int unsigned rx_count;
        bit          past_limit;
        walk_state_e walk_state;
        logic [7:0]  cur_code;
        logic [7:0]  cur_len;
        logic [7:0]  bytes_left;
        logic [31:0] value_acc;
        bit          cookie_match;
        logic [31:0] yiaddr_acc;
        logic [7:0]  type_seen;
        logic [31:0] word_val [4];
        logic [3:0]  word_found;
        bit          walk_stopped;
        result_t     expected_results [$];
        int unsigned failures;
        int unsigned bytes_taken;
        int unsigned status_count [5];

        function new();
            restart();
        endfunction

        // Per-message state goes back to its idle values after every reply.
        function void restart();
            rx_count     = 0;
            past_limit   = 1'b0;
            walk_state   = WANT_CODE;
            cur_code     = '0;
            cur_len      = '0;
            bytes_left   = '0;
            value_acc    = '0;
            cookie_match = 1'b1;
            yiaddr_acc   = '0;
            type_seen    = '0;
            foreach (word_val[i]) word_val[i] = '0;
            word_found   = '0;
            walk_stopped = 1'b0;
        endfunction

        // A completed option updates the type or one of the four word slots.
        function void apply_option();
            int         n;
            logic [1:0] slot;
            n = (cur_len < 4) ? int'(cur_len) : 4;
            if (cur_code == OPT_TYPE) begin
                if (cur_len != 8'd0) type_seen = 8'(value_acc >> (8 * (n - 1)));
                return;
            end
            if (cur_len < 4) return;
            case (cur_code)
                OPT_MASK:   slot = SLOT_MASK;
                OPT_ROUTER: slot = SLOT_ROUTER;
                OPT_DNS:    slot = SLOT_DNS;
                OPT_LEASE:  slot = SLOT_LEASE;
                default:    return;
            endcase
            word_val[slot]   = value_acc;
            word_found[slot] = 1'b1;
        endfunction

        // One byte at a known position within the message.
        function void absorb(int unsigned at, logic [7:0] b);
            if (at >= YIADDR_FIRST && at <= YIADDR_LAST) yiaddr_acc = {yiaddr_acc[23:0], b};
            if (at >= COOKIE_FIRST && at <= COOKIE_LAST && b != COOKIE[at - COOKIE_FIRST])
                cookie_match = 1'b0;
            if (at < OPTIONS_FIRST || walk_stopped) return;
            case (walk_state)
                WANT_CODE: begin
                    if (b == OPT_END) begin
                        walk_stopped = 1'b1;
                    end else if (b != OPT_PAD) begin
                        cur_code   = b;
                        walk_state = WANT_LEN;
                    end
                end
                WANT_LEN: begin
                    cur_len    = b;
                    bytes_left = b;
                    value_acc  = '0;
                    if (b == 8'd0) begin
                        apply_option();
                        walk_state = WANT_CODE;
                    end else begin
                        walk_state = IN_VALUE;
                    end
                end
                default: begin
                    // Only the first four value bytes are kept.
                    if (cur_len - bytes_left < 4) value_acc = {value_acc[23:0], b};
                    bytes_left--;
                    if (bytes_left == 8'd0) begin
                        apply_option();
                        walk_state = WANT_CODE;
                    end
                end
            endcase
        endfunction

        // Called for every accepted input word; the final byte yields a result.
        function void note_byte(logic [7:0] b, logic last);
            result_t want;
            bytes_taken++;
            if (rx_count >= MSG_LIMIT) begin
                past_limit = 1'b1;
            end else begin
                absorb(rx_count, b);
                rx_count++;
            end
            if (!last) return;
            want = '0;
            if (past_limit)                   want.status = STATUS_TOO_LONG;
            else if (rx_count < MIN_MSG_BYTES) want.status = STATUS_SHORT;
            else if (!cookie_match)           want.status = STATUS_BAD_COOKIE;
            else if (type_seen != TYPE_OFFER && type_seen != TYPE_ACK)
                want.status = STATUS_BAD_TYPE;
            else
                want.status = STATUS_OK;
            if (want.status == STATUS_OK || want.status == STATUS_BAD_TYPE) begin
                want.msg_type    = type_seen;
                want.subnet_mask = word_val[SLOT_MASK];
                want.router      = word_val[SLOT_ROUTER];
                want.dns_server  = word_val[SLOT_DNS];
                want.lease_time  = word_val[SLOT_LEASE];
                want.found       = word_found;
            end
            if (want.status == STATUS_OK) want.offered_ip = yiaddr_acc;
            expected_results.push_back(want);
            status_count[want.status]++;
            restart();
        endfunction

        function void match_field(string label, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s expected %h actual %h", $time, label, want, got);
            end
        endfunction

        // Called for every accepted result word.
        function void check_result(logic [175:0] word, logic [3:0] flags);
            result_t want;
            if (expected_results.size() == 0) begin
                failures++;
                $display("%0t: result with no reply outstanding, expected none actual %h / %h",
                         $time, word, flags);
                return;
            end
            want = expected_results.pop_front();
            match_field("status",       want.status,      word[2:0]);
            match_field("offered_ip",   want.offered_ip,  word[34:3]);
            match_field("msg_type",     want.msg_type,    word[42:35]);
            match_field("subnet_mask",  want.subnet_mask, word[74:43]);
            match_field("router",       want.router,      word[106:75]);
            match_field("dns_server",   want.dns_server,  word[138:107]);
            match_field("lease_time",   want.lease_time,  word[170:139]);
            match_field("mask_found",   want.found[0],    flags[0]);
            match_field("router_found", want.found[1],    flags[1]);
            match_field("dns_found",    want.found[2],    flags[2]);
            match_field("lease_found",  want.found[3],    flags[3]);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = '0;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [175:0] m_axis_tdata;
    logic [3:0]   m_axis_tuser;

    reply_scoreboard sb;
    logic [7:0]      reply_bytes [$];
    int              burst_left  = 0;
    bit              hold_req    = 1'b0;
    int unsigned     cycle_count = 0;
    int unsigned     input_stalls = 0;

    dhcp_reply_option_parser #(
        .MAX_MSG_BYTES (MSG_LIMIT)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Both channels are observed at the rising edge; input is noted first.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (s_axis_tvalid && !s_axis_tready) input_stalls++;
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: segments of steady, random, sparse or no readiness, and
    // one long hold when the stimulus asks for it.
    initial begin : result_sink
        int seg;
        int mode;
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                seg  = $urandom_range(1, 60);
                repeat (seg) begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom);
                        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                        default: m_axis_tready <= 1'b0;
                    endcase
                    @(negedge aclk);
                    if (hold_req) break;
                end
            end
        end
    end

    // Drives one byte from a falling edge and returns at the falling edge
    // after it was taken. Gaps are inserted between bursts of random length.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 800)
                                                      : $urandom_range(1, 48);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_reply();
        foreach (reply_bytes[i]) send_byte(reply_bytes[i], i == reply_bytes.size() - 1);
    endtask

    // Fixed header with random content, the offered address and the cookie,
    // one byte of which can be spoilt.
    function automatic void begin_reply(logic [31:0] ip, int bad_at);
        int         i;
        logic [7:0] b;
        reply_bytes.delete();
        for (i = 0; i < OPTIONS_FIRST; i++) begin
            b = 8'($urandom);
            if (i >= YIADDR_FIRST && i <= YIADDR_LAST) b = ip[8 * (YIADDR_LAST - i) +: 8];
            if (i >= COOKIE_FIRST) begin
                b = COOKIE[i - COOKIE_FIRST];
                if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
            end
            reply_bytes.push_back(b);
        end
    endfunction

    // The first four value bytes come from lead, most significant first.
    function automatic void add_option(logic [7:0] code, int len, logic [31:0] lead);
        int k;
        reply_bytes.push_back(code);
        reply_bytes.push_back(8'(len));
        for (k = 0; k < len; k++) begin
            if (k < 4) reply_bytes.push_back(lead[8 * (3 - k) +: 8]);
            else       reply_bytes.push_back(8'($urandom));
        end
    endfunction

    function automatic void add_noise(int n);
        repeat (n) reply_bytes.push_back(8'($urandom));
    endfunction

    function automatic void pad_to(int n);
        while (reply_bytes.size() < n) reply_bytes.push_back(OPT_PAD);
    endfunction

    function automatic logic [7:0] pick_type();
        logic [7:0] t;
        case ($urandom_range(0, 5))
            0, 1:    t = TYPE_OFFER;
            2, 3:    t = TYPE_ACK;
            default: t = 8'($urandom);
        endcase
        return t;
    endfunction

    // A random mix of word options of varied lengths, type options, pads and
    // unknown codes.
    function automatic void add_random_options();
        int n;
        int pick;
        n = $urandom_range(0, 12);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                add_option(WORD_CODES[$urandom_range(0, 3)],
                           ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9) : 4, $urandom);
            else if (pick < 45)
                add_option(OPT_TYPE, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1,
                           {pick_type(), 24'($urandom)});
            else if (pick < 60)
                reply_bytes.push_back(OPT_PAD);
            else if (pick < 85)
                add_option(8'($urandom_range(1, 254)), $urandom_range(0, 24), $urandom);
            else
                add_option(WORD_CODES[$urandom_range(0, 3)], $urandom_range(5, 40), $urandom);
        end
    endfunction

    task automatic noise_message(int len);
        reply_bytes.delete();
        add_noise(len);
        send_reply();
    endtask

    task automatic oversize_reply(int len);
        begin_reply($urandom, -1);
        add_option(OPT_TYPE, 1, {TYPE_ACK, 24'h0});
        add_noise(len - reply_bytes.size());
        send_reply();
    endtask

    // Mostly well-formed replies; some lack the end option, some are cut
    // short at a random byte, a few carry a spoilt cookie.
    task automatic random_reply();
        int shape;
        int cut;
        int bad_at;
        bad_at = ($urandom_range(0, 19) == 0) ? int'($urandom_range(COOKIE_FIRST, COOKIE_LAST))
                                               : -1;
        begin_reply($urandom, bad_at);
        if ($urandom_range(0, 99) < 85) add_option(OPT_TYPE, 1, {pick_type(), 24'h0});
        add_random_options();
        shape = $urandom_range(0, 9);
        if (shape < 7) begin
            reply_bytes.push_back(OPT_END);
            add_noise($urandom_range(0, 12));
        end
        pad_to(MIN_MSG_BYTES);
        if (shape >= 8 && reply_bytes.size() > MIN_MSG_BYTES) begin
            cut = $urandom_range(MIN_MSG_BYTES, reply_bytes.size() - 1);
            while (reply_bytes.size() > cut) void'(reply_bytes.pop_back());
        end
        send_reply();
    endtask

    task automatic directed_replies();
        int k;
        // A message of one byte.
        reply_bytes.delete();
        reply_bytes.push_back(8'hFF);
        send_reply();
        // One byte short of the minimum with a good cookie.
        begin_reply(32'h0A000001, -1);
        add_option(OPT_TYPE, 1, {TYPE_OFFER, 24'h0});
        send_reply();
        // The smallest complete offer.
        begin_reply('1, -1);
        add_option(OPT_TYPE, 1, {TYPE_OFFER, 24'h0});
        reply_bytes.push_back(OPT_END);
        send_reply();
        // An ack with every option, pads, a long router list and options
        // after the end option that must be ignored.
        begin_reply('0, -1);
        repeat (3) reply_bytes.push_back(OPT_PAD);
        add_option(OPT_TYPE, 1, {TYPE_ACK, 24'h0});
        add_option(OPT_MASK, 4, 32'hFFFFFF00);
        add_option(OPT_ROUTER, 8, 32'hC0A80001);
        add_option(OPT_DNS, 4, '1);
        add_option(OPT_LEASE, 4, 32'h00015180);
        reply_bytes.push_back(OPT_END);
        add_option(OPT_TYPE, 1, {8'd1, 24'h0});
        add_option(OPT_MASK, 4, '0);
        send_reply();
        // A spoilt cookie at each of its four bytes.
        for (k = 0; k < 4; k++) begin
            begin_reply($urandom, COOKIE_FIRST + k);
            add_option(OPT_TYPE, 1, {TYPE_ACK, 24'h0});
            add_option(OPT_MASK, 4, $urandom);
            reply_bytes.push_back(OPT_END);
            send_reply();
        end
        // A type other than offer or ack still reports its options.
        begin_reply($urandom, -1);
        add_option(OPT_TYPE, 1, {8'd255, 24'h0});
        add_option(OPT_ROUTER, 4, $urandom);
        reply_bytes.push_back(OPT_END);
        send_reply();
        // No type option at all; a mask of three bytes is not taken.
        begin_reply($urandom, -1);
        add_option(OPT_MASK, 3, $urandom);
        add_option(OPT_DNS, 4, $urandom);
        reply_bytes.push_back(OPT_END);
        send_reply();
        // Zero lengths, a repeated mask, long values and a three-byte type.
        begin_reply($urandom, -1);
        add_option(OPT_TYPE, 1, {TYPE_ACK, 24'h0});
        add_option(OPT_TYPE, 0, '0);
        add_option(OPT_MASK, 0, '0);
        add_option(OPT_MASK, 4, 32'hFFFF0000);
        add_option(OPT_MASK, 4, 32'hFFFFFFFC);
        add_option(OPT_DNS, 12, $urandom);
        add_option(OPT_LEASE, 255, $urandom);
        add_option(OPT_TYPE, 3, {TYPE_OFFER, 24'($urandom)});
        reply_bytes.push_back(OPT_END);
        send_reply();
        // A router option cut short by the final byte.
        begin_reply($urandom, -1);
        add_option(OPT_TYPE, 1, {TYPE_OFFER, 24'h0});
        add_option(OPT_LEASE, 4, $urandom);
        add_option(OPT_ROUTER, 4, $urandom);
        void'(reply_bytes.pop_back());
        void'(reply_bytes.pop_back());
        send_reply();
        // A message that ends on an option code.
        begin_reply($urandom, -1);
        add_option(OPT_TYPE, 1, {TYPE_ACK, 24'h0});
        reply_bytes.push_back(OPT_LEASE);
        send_reply();
        // Exactly at the size limit, with an option ending on the last byte.
        begin_reply($urandom, -1);
        add_option(OPT_TYPE, 1, {TYPE_ACK, 24'h0});
        pad_to(MSG_LIMIT - 6);
        add_option(OPT_LEASE, 4, $urandom);
        send_reply();
        // One byte over the size limit.
        oversize_reply(MSG_LIMIT + 1);
    endtask

    // Many tiny messages while the receiver holds off, so that the queue
    // fills and the input stalls.
    task automatic backpressure_burst();
        hold_req = 1'b1;
        repeat (12) noise_message($urandom_range(1, 3));
    endtask

    initial begin : stimulus
        int m;
        int pick;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_replies();
        for (m = 0; m < RANDOM_REPLIES; m++) begin
            if (m == RANDOM_REPLIES / 2) backpressure_burst();
            pick = $urandom_range(0, 99);
            if (pick < 15)      noise_message($urandom_range(1, MIN_MSG_BYTES - 1));
            else if (pick < 18) oversize_reply(MSG_LIMIT + $urandom_range(1, 24));
            else                random_reply();
        end
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding results, then allow for the pipeline.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d bytes: %0d ok, %0d short, %0d bad cookie, %0d wrong type, %0d too long.",
                 sb.bytes_taken, sb.status_count[STATUS_OK], sb.status_count[STATUS_SHORT],
                 sb.status_count[STATUS_BAD_COOKIE], sb.status_count[STATUS_BAD_TYPE],
                 sb.status_count[STATUS_TOO_LONG]);
        $display("Byte input was stalled on %0d cycles; %0d mismatches were found.",
                 input_stalls, sb.failures);
        if (sb.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
